[design/tspq_pkg.sv]
// ----------------------------------------------------------------------------
// tspq_pkg
// Shared constants and types for the three-level stable priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tspq_pkg;

  // default sizing
  localparam int CAPACITY_DEF = 16;
  localparam int TAG_BITS_DEF = 16;

  // class codes as stored and reported
  localparam logic [1:0] CLASS_HIGH   = 2'd0;
  localparam logic [1:0] CLASS_MEDIUM = 2'd1;
  localparam logic [1:0] CLASS_LOW    = 2'd2;

  // command codes
  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DATA
  } state_t;

  // map an input class code onto a stored class, code three counts as low
  function automatic logic [1:0] class_of(input logic [1:0] code);
    logic [1:0] cls;
    cls = CLASS_LOW;
    if (code == CLASS_HIGH) begin
      cls = CLASS_HIGH;
    end else if (code == CLASS_MEDIUM) begin
      cls = CLASS_MEDIUM;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

[design/tspq_store.sv]
// ----------------------------------------------------------------------------
// tspq_store
// Tag memory, one region per class, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tspq_store #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 16,
  parameter int DEPTH  = 48
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[design/three_level_stable_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// three_level_stable_priority_queue_top
// Stable priority queue with three classes, built as three circular queues
// sharing one tag memory; the front is the head of the best nonempty class.
// ----------------------------------------------------------------------------
// After an input transfer the sequencer steps through ST_READ (memory read of the
// new front) and ST_DATA (result load, held while the output register is full),
// then returns to ST_IDLE; no new input is taken until the result is loaded.
// The next input is taken while a result still waits on the output.
// Reset clears counts, pointers, sequencer and output valid; the queue is
// empty at once and the tag memory needs no clearing pass.
`default_nettype none

module three_level_stable_priority_queue_top #(
  parameter int CAPACITY = tspq_pkg::CAPACITY_DEF,
  parameter int TAG_BITS = tspq_pkg::TAG_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // priority_class[1:0], task_tag[17:2]
  input  wire logic        s_axis_tuser,  // cmd[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata   // front_valid[0], front_class[2:1],
                                          // front_tag[18:3], entry_count[23:19],
                                          // dropped[24]
);

  localparam int PW     = $clog2(CAPACITY);
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int ADDR_W = PW + 2;
  localparam int DEPTH  = 3 * (2 ** PW);

  tspq_pkg::state_t state, state_next;

  logic [PW-1:0]       head [3];
  logic [PW-1:0]       tail [3];
  logic [CW-1:0]       cnt  [3];
  logic [CW-1:0]       total;
  logic                drop_flag;

  logic                in_xfer;
  logic                in_cmd;
  logic [1:0]          in_cls;
  logic [TAG_BITS-1:0] in_tag;
  logic                full;
  logic                do_enq;
  logic                do_deq;
  logic [1:0]          front_cls;

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [TAG_BITS-1:0] rd_data;
  logic                out_load;

  // input decode
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign in_cmd  = s_axis_tuser;
  assign in_cls  = tspq_pkg::class_of(s_axis_tdata[1:0]);
  assign in_tag  = TAG_BITS'(s_axis_tdata[17:2]);
  assign full    = (total == CW'(CAPACITY));
  assign do_enq  = in_xfer && (in_cmd == tspq_pkg::CMD_ENQUEUE) && !full;
  assign do_deq  = in_xfer && (in_cmd == tspq_pkg::CMD_DEQUEUE) && (total != '0);

  // best nonempty class
  always_comb begin
    front_cls = tspq_pkg::CLASS_LOW;
    if (cnt[tspq_pkg::CLASS_HIGH] != '0) begin
      front_cls = tspq_pkg::CLASS_HIGH;
    end else if (cnt[tspq_pkg::CLASS_MEDIUM] != '0) begin
      front_cls = tspq_pkg::CLASS_MEDIUM;
    end
  end

  // pointer advance with wrap at the capacity
  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  // memory ports
  assign wr_en   = do_enq;
  assign wr_addr = {in_cls, tail[in_cls]};
  assign rd_addr = {front_cls, head[front_cls]};

  tspq_store #(
    .ADDR_W (ADDR_W),
    .DATA_W (TAG_BITS),
    .DEPTH  (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_tag),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        cnt[i]  <= '0;
      end
      total     <= '0;
      drop_flag <= 1'b0;
    end else if (in_xfer) begin
      drop_flag <= (in_cmd == tspq_pkg::CMD_ENQUEUE) && full;
      if (do_enq) begin
        tail[in_cls] <= ptr_inc(tail[in_cls]);
        cnt[in_cls]  <= cnt[in_cls] + 1'b1;
        total        <= total + 1'b1;
      end else if (do_deq) begin
        head[front_cls] <= ptr_inc(head[front_cls]);
        cnt[front_cls]  <= cnt[front_cls] - 1'b1;
        total           <= total - 1'b1;
      end
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tspq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state and controls
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    rd_en         = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      tspq_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = tspq_pkg::ST_READ;
        end
      end
      tspq_pkg::ST_READ: begin
        rd_en      = 1'b1;
        state_next = tspq_pkg::ST_DATA;
      end
      tspq_pkg::ST_DATA: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = tspq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tspq_pkg::ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata[0]     <= (total != '0);
      m_axis_tdata[2:1]   <= (total != '0) ? front_cls : tspq_pkg::CLASS_HIGH;
      m_axis_tdata[18:3]  <= (total != '0) ? 16'(rd_data) : 16'd0;
      m_axis_tdata[23:19] <= 5'(total);
      m_axis_tdata[24]    <= drop_flag;
      m_axis_tdata[31:25] <= '0;
    end
  end

  // class counts always add up to the total
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    (CW + 2)'(total) == (CW + 2)'(cnt[0]) + (CW + 2)'(cnt[1]) + (CW + 2)'(cnt[2]))
    else $error("class counts disagree with total");

  // the total never goes past the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // an enqueue into a full queue changes nothing
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (in_cmd == tspq_pkg::CMD_ENQUEUE) && full |=> $stable(total) && drop_flag)
    else $error("enqueue on full queue was not dropped");

  // only one item in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("input taken while an item is in flight");

endmodule

`default_nettype wire

[sim/three_level_stable_priority_queue_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_level_stable_priority_queue_top_test
// Streams enqueue and dequeue commands into the priority queue with random
// gaps on both sides. A tracker keeps the service order and checks each
// reported front entry, count and drop flag.
// ----------------------------------------------------------------------------

// one reported queue status, as unpacked from the result transfer
typedef struct packed {
  logic        front_valid;
  logic [1:0]  front_class;
  logic [15:0] front_tag;
  logic [4:0]  entry_count;
  logic        dropped;
} front_status_t;

// service-order tracker and status checker
class queue_tracker;
  localparam int DEPTH = tspq_pkg::CAPACITY_DEF;

  logic [1:0]    class_slot[DEPTH];
  logic [15:0]   tag_slot[DEPTH];
  int unsigned   held;
  front_status_t awaited_status[$];
  int unsigned   errors;
  int unsigned   statuses_seen;

  function new();
    held          = 0;
    errors        = 0;
    statuses_seen = 0;
  endfunction

  function int unsigned pending();
    return awaited_status.size();
  endfunction

  task report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] status %0d: %s got 0x%0h, expected 0x%0h",
             $time, statuses_seen, what, got, want);
    errors++;
  endtask

  // apply one accepted command and queue the status it should produce
  task note_command(logic cmd, logic [1:0] code, logic [15:0] tag);
    front_status_t status;
    logic [1:0]    cls;
    int unsigned   pos;
    status = '0;
    if (cmd == tspq_pkg::CMD_ENQUEUE) begin
      // code three falls into the low class
      cls = (code == tspq_pkg::CLASS_HIGH || code == tspq_pkg::CLASS_MEDIUM) ?
            code : tspq_pkg::CLASS_LOW;
      if (held >= DEPTH) begin
        status.dropped = 1'b1;
      end else begin
        // go behind every entry of equal or better class
        pos = 0;
        while (pos < held && class_slot[pos] <= cls) pos++;
        for (int i = int'(held); i > int'(pos); i--) begin
          class_slot[i] = class_slot[i-1];
          tag_slot[i]   = tag_slot[i-1];
        end
        class_slot[pos] = cls;
        tag_slot[pos]   = tag;
        held++;
      end
    end else if (held > 0) begin
      for (int i = 1; i < int'(held); i++) begin
        class_slot[i-1] = class_slot[i];
        tag_slot[i-1]   = tag_slot[i];
      end
      held--;
    end
    // empty queue reports zero class and tag
    if (held > 0) begin
      status.front_valid = 1'b1;
      status.front_class = class_slot[0];
      status.front_tag   = tag_slot[0];
    end
    status.entry_count = 5'(held);
    awaited_status.push_back(status);
  endtask

  // compare one result transfer against the oldest expectation
  task check_front(logic [31:0] data);
    front_status_t want;
    front_status_t got;
    got.front_valid = data[0];
    got.front_class = data[2:1];
    got.front_tag   = data[18:3];
    got.entry_count = data[23:19];
    got.dropped     = data[24];
    if (awaited_status.size() == 0) begin
      report_mismatch("unexpected result", data, 0);
    end else begin
      want = awaited_status.pop_front();
      if (got.front_valid !== want.front_valid)
        report_mismatch("front_valid", got.front_valid, want.front_valid);
      if (got.front_class !== want.front_class)
        report_mismatch("front_class", got.front_class, want.front_class);
      if (got.front_tag !== want.front_tag)
        report_mismatch("front_tag", got.front_tag, want.front_tag);
      if (got.entry_count !== want.entry_count)
        report_mismatch("entry_count", got.entry_count, want.entry_count);
      if (got.dropped !== want.dropped)
        report_mismatch("dropped", got.dropped, want.dropped);
    end
    statuses_seen++;
  endtask
endclass

module three_level_stable_priority_queue_top_test;

  localparam int RANDOM_COMMANDS = 800;
  localparam int STALL_LIMIT     = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // priority_class[1:0], task_tag[17:2]
  logic        s_axis_tuser = 1'b0;  // cmd[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // front_valid[0], front_class[2:1], front_tag[18:3],
                              // entry_count[23:19], dropped[24]

  queue_tracker sb = new();
  bit           calm = 1'b0;
  int           sink_hold = 0;
  int           quiet_cycles = 0;

  three_level_stable_priority_queue_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // idle stretch length: mostly none or short, now and then long
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm) sink_hold = idle_length();
    end
  end

  // transfer monitor: results first, then the command taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_front(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_command(s_axis_tuser, s_axis_tdata[1:0], s_axis_tdata[17:2]);
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("three_level_stable_priority_queue_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // drive one command and hold it until the transfer happens
  task automatic send_command(logic cmd, logic [1:0] code, logic [15:0] tag);
    int gap;
    gap = calm ? 0 : idle_length();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {6'b0, tag, code};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic enqueue(logic [1:0] code, logic [15:0] tag);
    send_command(tspq_pkg::CMD_ENQUEUE, code, tag);
  endtask

  task automatic dequeue();
    send_command(tspq_pkg::CMD_DEQUEUE, 2'($urandom_range(0, 3)),
                 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    int sent;
    int burst;
    int enqueue_pct;
    sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: dequeue while empty, every class code, tag extremes
    dequeue();
    enqueue(2'd3, 16'hFFFF);
    enqueue(tspq_pkg::CLASS_HIGH, 16'h0000);
    enqueue(tspq_pkg::CLASS_MEDIUM, 16'h8001);
    enqueue(tspq_pkg::CLASS_LOW, 16'h7FFE);
    // second high entry must line up behind the first
    enqueue(tspq_pkg::CLASS_HIGH, 16'h1234);
    dequeue();
    dequeue();
    // fill to capacity, then push into a full queue
    for (int i = 0; i < 13; i++) enqueue(2'(i), 16'(16'hA500 + i));
    enqueue(tspq_pkg::CLASS_LOW, 16'h5A5A);
    enqueue(tspq_pkg::CLASS_HIGH, 16'hFFFF);

    // random bursts, each with its own enqueue bias so fill level swings
    while (sent < RANDOM_COMMANDS) begin
      burst       = $urandom_range(20, 60);
      enqueue_pct = $urandom_range(10, 90);
      calm        = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < burst; i++) begin
        if ($urandom_range(0, 99) < enqueue_pct)
          enqueue(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
        else
          dequeue();
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;
    calm = 1'b0;

    // drain outstanding results, then allow for pipeline latency
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.pending() != 0) sb.report_mismatch("missing results", 0, sb.pending());

    if (sb.errors == 0) begin
      $display("three_level_stable_priority_queue_top verification clean");
    end else begin
      $display("three_level_stable_priority_queue_top verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/tspq_pkg.sv
design/tspq_store.sv
design/three_level_stable_priority_queue_top.sv
sim/three_level_stable_priority_queue_top_test.sv
